### hw/rtl/cmdp_pkg.sv
// ----------------------------------------------------------------------------
// cmdp_pkg
// Shared types and constants for the command field parser.
// ----------------------------------------------------------------------------
package cmdp_pkg;

   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_PERIOD = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_SYNTAX   = 2'd1,
      ST_TOO_MANY = 2'd2
   } status_type;

   typedef enum logic {
      KIND_FIELD   = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  field_index;
      logic [30:0] field_value;
      logic [4:0]  field_count;
      status_type  status;
      logic        last;
   } result_type;

endpackage

### hw/rtl/command_field_parser.sv
// ----------------------------------------------------------------------------
// command_field_parser
// Byte-serial parser for text commands of the form #f0,f1,...,fn.
//
// Channel | Direction | Payload
// req     | in        | tdata: char_in; tlast: end_of_command
// rsp     | out       | tdata: field_index, field_value, field_count, status;
//         |           | tuser: item_kind; tlast: last_of_run
//
// One byte is parsed per cycle while req_tready is high, in the accepting
// cycle itself; its zero, one or two results enter a four-entry queue and
// leave one per cycle while rsp_tready is high. One-result bytes sustain one
// transaction per cycle; a byte that ends a field and the command yields two.
// req_tready is registered and is high while at least two queue entries are
// free. Reset is synchronous and returns the parser to the start of a command
// and empties the queue. Output stalls back up only through the queue.
// ----------------------------------------------------------------------------
module command_field_parser
   import cmdp_pkg::*;
#(
   parameter int MAX_FIELDS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tlast,   // end_of_command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [3:0] field_index, [34:4] field_value,
                                    // [39:35] field_count, [41:40] status
   output logic        rsp_tuser,   // item_kind
   output logic        rsp_tlast    // last_of_run
);

   localparam int FW = $clog2(MAX_FIELDS + 1);
   localparam logic [FW-1:0] FIELDS_LIMIT = FW'(MAX_FIELDS);

   logic          at_start_ff, at_start_in;
   logic          start_valid_ff, start_valid_in;
   logic [30:0]   value_ff, value_in;
   logic [FW-1:0] done_ff, done_in;
   logic          overflow_ff, overflow_in;

   result_type    queue_ff [4];
   logic [1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [2:0]    count_ff, count_in;
   logic          ready_ff;

   logic          accept, pop;
   logic          first, is_digit, is_sep, emit_field, syntax_ok;
   logic [34:0]   value_next;
   logic [6:0]    done_ext, done_in_ext;
   result_type    res0, res1;
   logic [1:0]    n_res;
   logic [1:0]    wr_ptr_next;

   assign accept   = req_tvalid && ready_ff;
   assign pop      = rsp_tvalid && rsp_tready;
   assign first    = at_start_ff;
   assign is_digit = (req_tdata >= CHAR_ZERO) && (req_tdata <= CHAR_NINE);
   assign is_sep   = (req_tdata == CHAR_COMMA) || (req_tdata == CHAR_PERIOD);
   assign emit_field = !first && is_sep && (done_ff < FIELDS_LIMIT);
   assign value_next = {value_ff, 3'b000} + {3'b000, value_ff, 1'b0}
                     + {31'd0, req_tdata[3:0]};
   assign done_ext    = 7'(done_ff);
   assign done_in_ext = 7'(done_in);
   assign syntax_ok   = start_valid_ff && !first && (req_tdata == CHAR_PERIOD);

   always_comb begin
      at_start_in    = at_start_ff;
      start_valid_in = start_valid_ff;
      value_in       = value_ff;
      done_in        = done_ff;
      overflow_in    = overflow_ff;
      if (first) begin
         start_valid_in = (req_tdata == CHAR_HASH);
         at_start_in    = 1'b0;
      end else if (is_digit) begin
         value_in = (value_next > 35'(VALUE_MAX)) ? VALUE_MAX : value_next[30:0];
      end else if (is_sep) begin
         if (emit_field) begin
            done_in = done_ff + FW'(1);
         end else begin
            overflow_in = 1'b1;
         end
         value_in = '0;
      end
   end

   always_comb begin
      res0 = '0;
      res1 = '0;
      res0.kind        = KIND_FIELD;
      res0.field_index = done_ext[3:0];
      res0.field_value = value_ff;
      res0.last        = !req_tlast;
      res1.kind        = KIND_SUMMARY;
      res1.field_count = syntax_ok ? done_in_ext[4:0] : 5'd0;
      res1.status      = !syntax_ok ? ST_SYNTAX : (overflow_in ? ST_TOO_MANY : ST_OK);
      res1.last        = 1'b1;
      n_res            = 2'(emit_field) + 2'(req_tlast);
      if (!emit_field) begin
         res0 = res1;
      end
   end

   assign wr_ptr_next = wr_ptr_ff + 2'd1;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = count_in + 3'(n_res);
      end
      if (pop) begin
         count_in = count_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff    <= 1'b1;
         start_valid_ff <= 1'b0;
         value_ff       <= '0;
         done_ff        <= '0;
         overflow_ff    <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
         ready_ff       <= 1'b0;
      end else begin
         if (accept) begin
            if (req_tlast) begin
               at_start_ff    <= 1'b1;
               start_valid_ff <= 1'b0;
               value_ff       <= '0;
               done_ff        <= '0;
               overflow_ff    <= 1'b0;
            end else begin
               at_start_ff    <= at_start_in;
               start_valid_ff <= start_valid_in;
               value_ff       <= value_in;
               done_ff        <= done_in;
               overflow_ff    <= overflow_in;
            end
            wr_ptr_ff <= wr_ptr_ff + n_res;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_in;
         ready_ff <= (count_in <= 3'd2);
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (n_res != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= res0;
         if (n_res == 2'd2) begin
            queue_ff[wr_ptr_next] <= res1;
         end
      end
   end

   assign req_tready = ready_ff;
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tuser  = queue_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last;
   assign rsp_tdata  = {6'd0,
                        queue_ff[rd_ptr_ff].status,
                        queue_ff[rd_ptr_ff].field_count,
                        queue_ff[rd_ptr_ff].field_value,
                        queue_ff[rd_ptr_ff].field_index};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue count beyond depth");

   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (count_ff <= 3'd2))
      else $error("input ready without room for two results");

   a_fields_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff <= FIELDS_LIMIT)
      else $error("field count beyond maximum");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (at_start_ff && (done_ff == '0)))
      else $error("parser did not return to start after end of command");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 3'd0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with empty count");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for command_field_parser. A short table of directed
// command bytes, some with hand-written results, is followed by random
// commands: mostly well-formed ones with random fields, plus bad leading
// bytes, missing periods, one-byte commands and plain noise. An internal
// parser model predicts every result, and each output transaction is checked
// against the oldest prediction. Both sides idle at random, the receiver
// holds off once for a long stretch, and the sender drains twice mid-run.
// ----------------------------------------------------------------------------
module testbench
   import cmdp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_FIELDS    = 16;
   localparam int ITEM_TARGET   = 1500;
   localparam int STALL_LIMIT   = 2000;
   localparam int HOLD_START    = 400;
   localparam int HOLD_CYCLES   = 120;
   localparam int QUIET_FIRST   = 1600;
   localparam int QUIET_LAST    = 2200;
   localparam int IDLE_PERCENT  = 34;
   localparam int REPORT_LIMIT  = 10;
   localparam int DRAIN_CYCLES  = 20;

   localparam logic [7:0] CHAR_LETTER_A = 8'h41;
   localparam logic [7:0] CHAR_LETTER_X = 8'h58;
   localparam logic [7:0] CHAR_NUL      = 8'h00;
   localparam logic [7:0] CHAR_ALL_ONES = 8'hFF;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic [1:0] n_typed;
      result_type r0;
      result_type r1;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] char_in
   logic        req_tlast = 1'b0;    // end_of_command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;           // [3:0] field_index, [34:4] field_value,
                                     // [39:35] field_count, [41:40] status
   logic        rsp_tuser;           // item_kind
   logic        rsp_tlast;           // last_of_run

   stim_row_type command_bytes[$];
   result_type   expected_results[$];

   int cycle_count = 0;
   int stall_cycles = 0;
   int accepted_bytes = 0;
   int mismatches = 0;
   int directed_count = 0;

   logic        at_start = 1'b1;
   logic        lead_ok = 1'b0;
   logic [30:0] accum = '0;
   int          fields_closed = 0;
   logic        overflow = 1'b0;

   command_field_parser #(
      .MAX_FIELDS(MAX_FIELDS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic result_type field_result(logic [3:0] idx, logic [30:0] val,
                                               logic last);
      result_type r;
      r = '0;
      r.kind = KIND_FIELD;
      r.field_index = idx;
      r.field_value = val;
      r.status = ST_OK;
      r.last = last;
      return r;
   endfunction

   function automatic result_type summary_result(logic [4:0] cnt, status_type st);
      result_type r;
      r = '0;
      r.kind = KIND_SUMMARY;
      r.field_count = cnt;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void add_byte(logic [7:0] ch, logic last, logic [1:0] n_typed,
                                    result_type r0, result_type r1);
      stim_row_type row;
      row.ch = ch;
      row.last = last;
      row.n_typed = n_typed;
      row.r0 = r0;
      row.r1 = r1;
      command_bytes.push_back(row);
   endfunction

   function automatic logic [7:0] filler_byte();
      logic [7:0] ch;
      do
         ch = 8'($urandom_range(255));
      while ((ch >= CHAR_ZERO && ch <= CHAR_NINE) || ch == CHAR_COMMA || ch == CHAR_PERIOD);
      return ch;
   endfunction

   function automatic logic [7:0] random_digit();
      return CHAR_ZERO + 8'($urandom_range(9));
   endfunction

   // Advances the parser model by one byte and returns the results it causes.
   task automatic parse_byte(input logic [7:0] ch, input logic eoc, output int n,
                             output result_type r0, output result_type r1);
      logic        first;
      logic        syntax_ok;
      logic [35:0] wide;
      result_type  summ;
      first = at_start;
      n = 0;
      r0 = '0;
      r1 = '0;
      if (first) begin
         lead_ok = (ch == CHAR_HASH);
         at_start = 1'b0;
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         wide = 36'(accum) * 36'd10 + 36'(ch - CHAR_ZERO);
         accum = (wide > 36'(VALUE_MAX)) ? VALUE_MAX : wide[30:0];
      end else if (ch == CHAR_COMMA || ch == CHAR_PERIOD) begin
         if (fields_closed < MAX_FIELDS) begin
            r0 = field_result(fields_closed[3:0], accum, !eoc);
            n = 1;
            fields_closed++;
         end else begin
            overflow = 1'b1;
         end
         accum = '0;
      end
      if (eoc) begin
         syntax_ok = lead_ok && !first && ch == CHAR_PERIOD;
         if (!syntax_ok)
            summ = summary_result(5'd0, ST_SYNTAX);
         else if (overflow)
            summ = summary_result(fields_closed[4:0], ST_TOO_MANY);
         else
            summ = summary_result(fields_closed[4:0], ST_OK);
         if (n == 0)
            r0 = summ;
         else
            r1 = summ;
         n++;
         at_start = 1'b1;
         lead_ok = 1'b0;
         accum = '0;
         fields_closed = 0;
         overflow = 1'b0;
      end
   endtask

   function automatic logic quiet_stretch();
      return cycle_count >= QUIET_FIRST && cycle_count < QUIET_LAST;
   endfunction

   always @(posedge clock) begin : monitor
      stim_row_type row;
      int           n;
      result_type   p0;
      result_type   p1;
      result_type   got;
      result_type   want;
      logic         bad;
      if (!reset) begin
         cycle_count++;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (req_tvalid && req_tready) begin
            row = command_bytes[accepted_bytes];
            accepted_bytes++;
            parse_byte(req_tdata, req_tlast, n, p0, p1);
            if (row.n_typed != 2'd0) begin
               n = row.n_typed;
               p0 = row.r0;
               p1 = row.r1;
            end
            if (n > 0)
               expected_results.push_back(p0);
            if (n > 1)
               expected_results.push_back(p1);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind = kind_type'(rsp_tuser);
            got.field_index = rsp_tdata[3:0];
            got.field_value = rsp_tdata[34:4];
            got.field_count = rsp_tdata[39:35];
            got.status = status_type'(rsp_tdata[41:40]);
            got.last = rsp_tlast;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("Unexpected transaction at cycle %0d: kind=%0d index=%0d",
                           cycle_count, got.kind, got.field_index);
            end else begin
               want = expected_results.pop_front();
               bad = (got.kind !== want.kind) || (got.field_index !== want.field_index) ||
                     (got.field_value !== want.field_value) ||
                     (got.field_count !== want.field_count) ||
                     (got.status !== want.status) || (got.last !== want.last);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("Mismatch at cycle %0d", cycle_count);
                     $display("  expected kind=%0d index=%0d value=%0d count=%0d status=%0d last=%0d",
                              want.kind, want.field_index, want.field_value,
                              want.field_count, want.status, want.last);
                     $display("  actual   kind=%0d index=%0d value=%0d count=%0d status=%0d last=%0d",
                              got.kind, got.field_index, got.field_value,
                              got.field_count, got.status, got.last);
                  end
               end
            end
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (cycle_count == HOLD_START) begin
            rsp_tready <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
         end else if (quiet_stretch()) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   initial begin : sender
      int         idx;
      int         planned;
      int         pause_at;
      int         nsep;
      int         ndig;
      int         len;
      int         pick;
      logic [7:0] ch;
      result_type none;

      none = '0;
      // Malformed one-byte commands: bad leading byte and a lone hash.
      add_byte(CHAR_LETTER_X, 1'b1, 2'd1, summary_result(5'd0, ST_SYNTAX), none);
      add_byte(CHAR_HASH, 1'b1, 2'd1, summary_result(5'd0, ST_SYNTAX), none);
      // A saturating field, ignored extreme bytes, and an empty final field.
      add_byte(CHAR_HASH, 1'b0, 2'd0, none, none);
      for (int i = 0; i < 10; i++)
         add_byte(CHAR_NINE, 1'b0, 2'd0, none, none);
      add_byte(CHAR_COMMA, 1'b0, 2'd1, field_result(4'd0, VALUE_MAX, 1'b1), none);
      add_byte(CHAR_ALL_ONES, 1'b0, 2'd0, none, none);
      add_byte(CHAR_NUL, 1'b0, 2'd0, none, none);
      add_byte(CHAR_PERIOD, 1'b1, 2'd2, field_result(4'd1, '0, 1'b0),
               summary_result(5'd2, ST_OK));
      // Command that ends on a comma instead of a period.
      add_byte(CHAR_HASH, 1'b0, 2'd0, none, none);
      add_byte(CHAR_ZERO + 8'd5, 1'b0, 2'd0, none, none);
      add_byte(CHAR_COMMA, 1'b1, 2'd2, field_result(4'd0, 31'd5, 1'b0),
               summary_result(5'd0, ST_SYNTAX));
      // Well-formed body behind a bad leading byte.
      add_byte(CHAR_LETTER_A, 1'b0, 2'd0, none, none);
      add_byte(CHAR_ZERO + 8'd7, 1'b0, 2'd0, none, none);
      add_byte(CHAR_PERIOD, 1'b1, 2'd2, field_result(4'd0, 31'd7, 1'b0),
               summary_result(5'd0, ST_SYNTAX));
      directed_count = command_bytes.size();

      planned = 0;
      while (planned < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 78) begin
            if ($urandom_range(99) < 8) begin
               do
                  ch = 8'($urandom_range(255));
               while (ch == CHAR_HASH);
            end else begin
               ch = CHAR_HASH;
            end
            add_byte(ch, 1'b0, 2'd0, none, none);
            planned++;
            nsep = ($urandom_range(9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 8);
            for (int s = 1; s <= nsep; s++) begin
               ndig = ($urandom_range(19) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
               for (int d = 0; d < ndig; d++) begin
                  if ($urandom_range(19) == 0)
                     add_byte(filler_byte(), 1'b0, 2'd0, none, none);
                  add_byte(random_digit(), 1'b0, 2'd0, none, none);
                  planned++;
               end
               if (s < nsep) begin
                  ch = CHAR_COMMA;
               end else if ($urandom_range(99) < 6) begin
                  do
                     ch = 8'($urandom_range(255));
                  while (ch == CHAR_PERIOD);
               end else begin
                  ch = CHAR_PERIOD;
               end
               add_byte(ch, s == nsep, 2'd0, none, none);
               planned++;
            end
         end else if (pick < 88) begin
            ch = ($urandom_range(3) == 0) ? CHAR_HASH : 8'($urandom_range(255));
            add_byte(ch, 1'b1, 2'd0, none, none);
            planned++;
         end else begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
               add_byte(8'($urandom_range(255)), k == len - 1, 2'd0, none, none);
               planned++;
            end
         end
      end
      pause_at = command_bytes.size() / 2;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idx = 0;
      while (idx < command_bytes.size()) begin
         if (idx == directed_count || idx == pause_at) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (expected_results.size() != 0)
               @(negedge clock);
         end
         @(negedge clock);
         if (!quiet_stretch() && $urandom_range(99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= command_bytes[idx].ch;
            req_tlast <= command_bytes[idx].last;
            do
               @(posedge clock);
            while (!req_tready);
            idx++;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/cmdp_pkg.sv
hw/rtl/command_field_parser.sv
tb/testbench.sv
